FILE: hw/rtl/swm_pkg.sv
// Shared types and constants for the sliding window maximum block.
package swm_pkg;

  localparam int MAX_WINDOW  = 64;
  localparam int SAMPLE_BITS = 32;
  localparam int AGE_BITS    = 7;
  localparam int WIN_BITS    = 7;

  typedef struct packed {
    logic                          valid;
    logic [AGE_BITS-1:0]           age;
    logic signed [SAMPLE_BITS-1:0] value;
  } cell_t;

  typedef struct packed {
    logic                          step;
    logic                          shift;
    logic                          purge;
    logic                          clear;
    logic signed [SAMPLE_BITS-1:0] sample;
  } cell_ctl_t;

  typedef enum logic {
    ST_RUN,
    ST_PURGE
  } swm_state_t;

endpackage

FILE: hw/rtl/swm_cell.sv
// One candidate cell of the monotonic candidate row.
module swm_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  swm_pkg::cell_ctl_t ctl_i,
  input  swm_pkg::cell_t    right_i,
  input  logic              prev_survive_i,
  output swm_pkg::cell_t    cell_o,
  output swm_pkg::cell_t    nxt_o,
  output logic              survive_o
);

  swm_pkg::cell_t cell_r;
  swm_pkg::cell_t cell_nxt;
  swm_pkg::cell_t src;

  always_comb begin
    src       = ctl_i.shift ? right_i : cell_r;
    survive_o = src.valid && !($signed(ctl_i.sample) >= $signed(src.value));
    if (survive_o) begin
      nxt_o.valid = 1'b1;
      nxt_o.age   = src.age + {{(swm_pkg::AGE_BITS-1){1'b0}}, 1'b1};
      nxt_o.value = src.value;
    end else if (prev_survive_i) begin
      // first free slot: take the new sample
      nxt_o.valid = 1'b1;
      nxt_o.age   = '0;
      nxt_o.value = ctl_i.sample;
    end else begin
      nxt_o.valid = 1'b0;
      nxt_o.age   = src.age;
      nxt_o.value = src.value;
    end
  end

  // Step on a sample (drop everything on a last sample), shift left on a purge.
  always_comb begin
    cell_nxt = cell_r;
    if (ctl_i.step) begin
      cell_nxt       = nxt_o;
      cell_nxt.valid = nxt_o.valid && !ctl_i.clear;
    end else if (ctl_i.purge) begin
      cell_nxt = right_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r <= '0;
    end else begin
      cell_r <= cell_nxt;
    end
  end

  assign cell_o = cell_r;

endmodule

FILE: hw/rtl/sliding_window_maximum.sv
// Top level of the sliding window maximum block: candidate row, control and output word.
// A result word appears in the output register in the cycle after its sample is taken.
// Throughput: one sample per cycle, through the update of the candidate cell row;
//   input stalls while the output register holds a word that is not taken, and during a purge.
// After a window_size write, in_ready stays low while the purge drops each candidate already
//   older than the new window (0 to 63), and until the purge is left. Reset clears all
//   candidates, the sample count and sets window_size to 1.
module sliding_window_maximum (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [swm_pkg::SAMPLE_BITS-1:0] in_sample,
  input  logic                                 in_last_sample,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [swm_pkg::SAMPLE_BITS-1:0] out_window_max,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [swm_pkg::WIN_BITS-1:0]         cfg_data
);

  localparam int N = swm_pkg::MAX_WINDOW;

  // Candidate row: cell 0 is the oldest candidate and always the window maximum.
  swm_pkg::cell_t     cells   [N];
  swm_pkg::cell_t     nxt     [N];
  logic               survive [N];
  swm_pkg::cell_ctl_t ctl;

  swm_pkg::swm_state_t state_r, state_nxt;

  logic [swm_pkg::WIN_BITS-1:0]  window_r;
  logic [swm_pkg::WIN_BITS-1:0]  win_eff;
  logic [swm_pkg::WIN_BITS-1:0]  seen_r, seen_nxt;
  logic                          out_valid_r;
  logic signed [swm_pkg::SAMPLE_BITS-1:0] out_max_r;

  logic in_fire, cfg_fire, purge_go, emit;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign in_ready  = (state_r == swm_pkg::ST_RUN) && (!out_valid_r || out_ready);
  assign in_fire   = in_valid && in_ready;

  // Clamp the register into the legal window range: zero acts as one.
  always_comb begin
    if (window_r == '0) begin
      win_eff = {{(swm_pkg::WIN_BITS-1){1'b0}}, 1'b1};
    end else if (window_r > swm_pkg::WIN_BITS'(N)) begin
      win_eff = swm_pkg::WIN_BITS'(N);
    end else begin
      win_eff = window_r;
    end
  end

  // Front candidate left over from a larger window: drop it during purge.
  assign purge_go = cells[0].valid && (cells[0].age >= win_eff);

  always_comb begin
    ctl.step   = in_fire;
    // Oldest candidate reaches the window length on this sample: shift the row left.
    ctl.shift  = in_fire ? (cells[0].valid &&
                 ((cells[0].age + {{(swm_pkg::AGE_BITS-1){1'b0}}, 1'b1}) >= win_eff))
                 : (state_r == swm_pkg::ST_PURGE);
    ctl.purge  = (state_r == swm_pkg::ST_PURGE) && purge_go && !cfg_fire;
    ctl.clear  = in_fire && in_last_sample;
    ctl.sample = in_sample;
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    swm_pkg::cell_t right;
    logic           prev_surv;
    if (i == N - 1) begin : g_end
      assign right = '0;
    end else begin : g_mid
      assign right = cells[i+1];
    end
    if (i == 0) begin : g_head
      assign prev_surv = 1'b1;
    end else begin : g_body
      assign prev_surv = survive[i-1];
    end
    swm_cell u_cell (
      .clk            (clk),
      .rst_n          (rst_n),
      .ctl_i          (ctl),
      .right_i        (right),
      .prev_survive_i (prev_surv),
      .cell_o         (cells[i]),
      .nxt_o          (nxt[i]),
      .survive_o      (survive[i])
    );
  end

  // Count samples of the current sequence, saturating at the window.
  always_comb begin
    seen_nxt = (seen_r < win_eff) ? seen_r + {{(swm_pkg::WIN_BITS-1){1'b0}}, 1'b1} : win_eff;
    emit     = seen_nxt >= win_eff;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      swm_pkg::ST_RUN: begin
        if (cfg_fire) state_nxt = swm_pkg::ST_PURGE;
      end
      swm_pkg::ST_PURGE: begin
        if (!cfg_fire && !purge_go) state_nxt = swm_pkg::ST_RUN;
      end
      default: state_nxt = swm_pkg::ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= swm_pkg::ST_RUN;
      window_r <= {{(swm_pkg::WIN_BITS-1){1'b0}}, 1'b1};
      seen_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_fire) window_r <= cfg_data;
      if (in_fire) seen_r <= in_last_sample ? '0 : seen_nxt;
    end
  end

  // Output word: load on each sample, hold until taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= emit;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) out_max_r <= nxt[0].value;
  end

  assign out_valid      = out_valid_r;
  assign out_window_max = out_max_r;

  // The second cell holds a candidate only if the first one does: no gap at the front.
  a_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    cells[1].valid |-> cells[0].valid)
    else $error("candidate row has a gap at the front");

  // While running, the front candidate is always inside the window.
  a_front_age: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == swm_pkg::ST_RUN) && cells[0].valid |-> cells[0].age < win_eff)
    else $error("front candidate older than window while running");

  // A last sample leaves an empty row and a zero count.
  a_last_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_last_sample |=> !cells[0].valid && (seen_r == '0))
    else $error("sequence state not cleared after last sample");

  // No sample is taken right after a window write.
  a_purge_stall: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_fire |=> !in_ready)
    else $error("input taken right after a window write");

endmodule
